@@ rtl/egc_pkg.sv @@
package egc_pkg;

   localparam int MAX_DIM_DEFAULT    = 1024;
   localparam int PIXEL_BITS_DEFAULT = 16;

   localparam int PIXEL_FIELD_BITS = 16;
   localparam int POS_FIELD_BITS   = 10;
   localparam int EDGE_FIELD_BITS  = 17;

   localparam int CSR_DATA_BITS   = 11;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int FRAME_DIM_RESET = 1024;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Bit positions of the pending-result mask, in the order results leave.
   localparam int RES_UP     = 0;
   localparam int RES_LEFT   = 1;
   localparam int RES_CORNER = 2;
   localparam int RES_KINDS  = 3;

endpackage

@@ rtl/egc_req_if.sv @@
interface egc_req_if;
   import egc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [PIXEL_FIELD_BITS-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);

endinterface

@@ rtl/egc_rsp_if.sv @@
interface egc_rsp_if;
   import egc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [POS_FIELD_BITS-1:0]  out_row;
   logic [POS_FIELD_BITS-1:0]  out_col;
   logic [EDGE_FIELD_BITS-1:0] edge_value;
   logic                       run_last;
   logic                       frame_last;

   modport source (
      output valid, output out_row, output out_col, output edge_value,
      output run_last, output frame_last, input ready
   );
   modport sink (
      input valid, input out_row, input out_col, input edge_value,
      input run_last, input frame_last, output ready
   );

endinterface

@@ rtl/edge_gradient_contour.sv @@
// Forward-difference gradient contour over a pixel stream in raster order.
// The req channel carries one grey pixel per transfer; the rsp channel gives
// one result per transfer with its row, column and the sum of the absolute
// differences to the pixel below and to the pixel on the right.
// Frame width and height are written through the csr port while idle; any
// write restarts the frame at row 0, column 0.
// A pixel is taken in every cycle while it causes at most one result, so
// every row but the bottom one streams at one pixel per cycle while rsp does
// not stall. A bottom-row pixel causes up to two results, the last pixel of
// a frame up to three, and the single rsp port gives them out one at a time.
// The transfer of a pixel reads the line buffer into the working register,
// and its first result then goes into the output register, which drives rsp
// valid, as soon as that register is free.
// When rsp stalls, one item waits in the working register and one result
// in the output register, after which req ready falls.
// Reset clears the counters, the left neighbor and all valid flags and sets
// both dimensions to their largest value; the line buffer is not cleared.
module edge_gradient_contour #(
   parameter int MAX_DIM    = egc_pkg::MAX_DIM_DEFAULT,
   parameter int PIXEL_BITS = egc_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [egc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [egc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   egc_req_if.sink                            req_if,
   egc_rsp_if.source                          rsp_if
);
   import egc_pkg::*;

   localparam int POS_BITS  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_BITS  = $clog2(MAX_DIM + 1);
   localparam int DIFF_BITS = PIXEL_BITS + 1;
   localparam int RESET_DIM = (FRAME_DIM_RESET > MAX_DIM) ? MAX_DIM : FRAME_DIM_RESET;

   function automatic logic [PIXEL_BITS-1:0] abs_diff(
      input logic [PIXEL_BITS-1:0] a,
      input logic [PIXEL_BITS-1:0] b
   );
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [DIM_BITS-1:0]   width_ff, height_ff, dim_clamped;
   logic [POS_BITS-1:0]   col_ff, col_in, row_ff, row_in;
   logic [PIXEL_BITS-1:0] left_ff, left_in;
   logic [DIM_BITS-1:0]   col_next1, row_next1;
   logic [POS_BITS-1:0]   right_addr;
   logic                  last_col, bottom_row;
   logic                  req_fire, csr_hit;
   logic [PIXEL_BITS-1:0] pix;

   logic [PIXEL_BITS-1:0] line_mem [MAX_DIM];
   logic [PIXEL_BITS-1:0] above_here_ff, above_right_ff;

   logic [RES_KINDS-1:0]  pend_ff, pend_in, new_mask, sel;
   logic [PIXEL_BITS-1:0] pix_s1_ff, left_s1_ff;
   logic [POS_BITS-1:0]   row_s1_ff, col_s1_ff;
   logic                  right_s1_ff;
   logic                  out_load, item_done;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [POS_FIELD_BITS-1:0]  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [EDGE_FIELD_BITS-1:0] rsp_edge_ff, rsp_edge_in;
   logic                       rsp_run_ff, rsp_frame_ff, rsp_frame_in;
   logic [DIFF_BITS-1:0]       up_value;

   // Configuration: sizes are stored already clamped to 1..MAX_DIM.
   always_comb begin
      if (csr_wdata == '0) begin
         dim_clamped = DIM_BITS'(1);
      end else if (32'(csr_wdata) > MAX_DIM) begin
         dim_clamped = DIM_BITS'(MAX_DIM);
      end else begin
         dim_clamped = DIM_BITS'(csr_wdata);
      end
   end

   always_comb begin
      case (csr_index_type'(csr_index))
         CSR_FRAME_WIDTH:  csr_hit = csr_we;
         CSR_FRAME_HEIGHT: csr_hit = csr_we;
         default:          csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(RESET_DIM);
         height_ff <= DIM_BITS'(RESET_DIM);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_ff  <= dim_clamped;
            CSR_FRAME_HEIGHT: height_ff <= dim_clamped;
            default: begin
            end
         endcase
      end
   end

   // Raster position and the flags of the pixel about to be taken.
   assign pix        = req_if.pixel[PIXEL_BITS-1:0];
   assign req_fire   = req_if.valid && req_if.ready;
   assign col_next1  = DIM_BITS'(col_ff) + DIM_BITS'(1);
   assign row_next1  = DIM_BITS'(row_ff) + DIM_BITS'(1);
   assign right_addr = POS_BITS'(col_next1);
   assign last_col   = (col_next1 >= width_ff);
   assign bottom_row = (row_next1 == height_ff);

   always_comb begin
      new_mask             = '0;
      new_mask[RES_UP]     = (row_ff != '0);
      new_mask[RES_LEFT]   = bottom_row && (col_ff != '0);
      new_mask[RES_CORNER] = bottom_row && last_col;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (csr_hit) begin
         col_in  = '0;
         row_in  = '0;
         left_in = '0;
      end else if (req_fire) begin
         left_in = pix;
         if (last_col) begin
            col_in = '0;
            row_in = (row_next1 >= height_ff) ? '0 : POS_BITS'(row_next1);
         end else begin
            col_in = POS_BITS'(col_next1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         left_ff <= left_in;
      end
   end

   // Line buffer: reads return the row above, the write stores this row.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         line_mem[col_ff] <= pix;
         above_here_ff    <= line_mem[col_ff];
         above_right_ff   <= line_mem[right_addr];
      end
   end

   // Working register: holds one item until all its results have left.
   assign sel       = pend_ff & (~pend_ff + RES_KINDS'(1));
   assign item_done = ((pend_ff & ~sel) == '0);
   assign out_load  = (pend_ff != '0) && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = (pend_ff == '0) || (out_load && item_done);

   always_comb begin
      if (req_fire) begin
         pend_in = new_mask;
      end else if (out_load) begin
         pend_in = pend_ff & ~sel;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pix_s1_ff   <= pix;
         left_s1_ff  <= left_ff;
         row_s1_ff   <= row_ff;
         col_s1_ff   <= col_ff;
         right_s1_ff <= !last_col;
      end
   end

   // Result of the lowest pending kind.
   always_comb begin
      up_value = DIFF_BITS'(abs_diff(pix_s1_ff, above_here_ff));
      if (right_s1_ff) begin
         up_value = up_value + DIFF_BITS'(abs_diff(above_right_ff, above_here_ff));
      end
   end

   always_comb begin
      rsp_row_in   = POS_FIELD_BITS'(row_s1_ff);
      rsp_col_in   = POS_FIELD_BITS'(col_s1_ff);
      rsp_edge_in  = '0;
      rsp_frame_in = 1'b0;
      if (sel[RES_UP]) begin
         rsp_row_in  = POS_FIELD_BITS'(row_s1_ff - POS_BITS'(1));
         rsp_edge_in = EDGE_FIELD_BITS'(up_value);
      end else if (sel[RES_LEFT]) begin
         rsp_col_in  = POS_FIELD_BITS'(col_s1_ff - POS_BITS'(1));
         rsp_edge_in = EDGE_FIELD_BITS'(abs_diff(pix_s1_ff, left_s1_ff));
      end else if (sel[RES_CORNER]) begin
         rsp_frame_in = 1'b1;
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_row_ff   <= rsp_row_in;
         rsp_col_ff   <= rsp_col_in;
         rsp_edge_ff  <= rsp_edge_in;
         rsp_run_ff   <= item_done;
         rsp_frame_ff <= rsp_frame_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_row    = rsp_row_ff;
   assign rsp_if.out_col    = rsp_col_ff;
   assign rsp_if.edge_value = rsp_edge_ff;
   assign rsp_if.run_last   = rsp_run_ff;
   assign rsp_if.frame_last = rsp_frame_ff;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
   import egc_pkg::*;

   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_PIXELS   = 64;

   typedef struct packed {
      logic [POS_FIELD_BITS-1:0]  row;
      logic [POS_FIELD_BITS-1:0]  col;
      logic [EDGE_FIELD_BITS-1:0] value;
      logic                       run_last;
      logic                       frame_last;
   } contour_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   egc_req_if req_bus ();
   egc_rsp_if rsp_bus ();

   edge_gradient_contour u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus)
   );

   logic [PIXEL_FIELD_BITS-1:0] pending_pixels[$];
   contour_type                 expected_contours[$];

   // Shadow copy of the block's frame state.
   logic [PIXEL_FIELD_BITS-1:0] line_buf[MAX_DIM_DEFAULT];
   logic [PIXEL_FIELD_BITS-1:0] left_pix = '0;
   logic [CSR_DATA_BITS-1:0]    frame_w  = CSR_DATA_BITS'(FRAME_DIM_RESET);
   logic [CSR_DATA_BITS-1:0]    frame_h  = CSR_DATA_BITS'(FRAME_DIM_RESET);
   int unsigned                 row_pos  = 0;
   int unsigned                 col_pos  = 0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   int error_count    = 0;

   function automatic int unsigned effective_dim(logic [CSR_DATA_BITS-1:0] dim);
      if (dim == 0) return 1;
      if (dim > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
      return 32'(dim);
   endfunction

   function automatic int unsigned pixel_distance(logic [PIXEL_FIELD_BITS-1:0] a,
                                                  logic [PIXEL_FIELD_BITS-1:0] b);
      return (a > b) ? 32'(a - b) : 32'(b - a);
   endfunction

   function automatic bit log_error();
      error_count++;
      return error_count <= REPORT_LIMIT;
   endfunction

   // Results of each pixel leave in this order: the pixel above, then the left neighbor
   // on the bottom row, then the corner.
   function automatic void predict_contours(logic [PIXEL_FIELD_BITS-1:0] pix);
      int unsigned w, h, r, c, grad;
      contour_type batch[$];
      w = effective_dim(frame_w);
      h = effective_dim(frame_h);
      r = row_pos;
      c = col_pos;
      if (r >= 1 && r < h && c < w) begin
         grad = pixel_distance(pix, line_buf[c]);
         if (c + 1 < w) grad += pixel_distance(line_buf[c + 1], line_buf[c]);
         batch.push_back(contour_type'{10'(r - 1), 10'(c), 17'(grad), 1'b0, 1'b0});
      end
      if (r + 1 == h) begin
         if (c >= 1) begin
            batch.push_back(contour_type'{10'(r), 10'(c - 1),
                                          17'(pixel_distance(pix, left_pix)), 1'b0, 1'b0});
         end
         if (c + 1 == w) batch.push_back(contour_type'{10'(r), 10'(c), 17'd0, 1'b0, 1'b1});
      end
      if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
      foreach (batch[i]) expected_contours.push_back(batch[i]);
      line_buf[c] = pix;
      left_pix = pix;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic logic [PIXEL_FIELD_BITS-1:0] next_pixel(
      logic [PIXEL_FIELD_BITS-1:0] prev);
      case ($urandom_range(3))
         0: return 16'($urandom());
         1: return $urandom_range(1) ? '1 : '0;
         default: return 16'(prev + $urandom_range(31) - 16);
      endcase
   endfunction

   task automatic push_pixels(int unsigned count);
      logic [PIXEL_FIELD_BITS-1:0] pix;
      pix = 16'($urandom());
      repeat (count) begin
         pix = next_pixel(pix);
         pending_pixels.push_back(pix);
      end
   endtask

   // Wait until every pixel is taken and every result has arrived.
   task automatic settle(int tail);
      while (pending_pixels.size() != 0 || req_bus.valid || expected_contours.size() != 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_frame(logic [CSR_DATA_BITS-1:0] w, logic [CSR_DATA_BITS-1:0] h);
      settle(SETTLE_CYCLES);
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Pixel driver.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) void'(pending_pixels.pop_front());
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.pixel <= pending_pixels[0];
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver, with an occasional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_seen != hold_request) begin
         hold_seen     <= hold_request;
         hold_left     <= LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: register writes, pixel transfers and result checks.
   always @(posedge clock) begin
      contour_type got, want;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == CSR_FRAME_WIDTH) frame_w = csr_wdata;
            else if (csr_index == CSR_FRAME_HEIGHT) frame_h = csr_wdata;
            row_pos  = 0;
            col_pos  = 0;
            left_pix = '0;
         end
         if (req_bus.valid && req_bus.ready) predict_contours(req_bus.pixel);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.out_row, rsp_bus.out_col, rsp_bus.edge_value,
                    rsp_bus.run_last, rsp_bus.frame_last};
            if (expected_contours.size() == 0) begin
               if (log_error())
                  $display("unexpected result: row %0d col %0d value %0d run_last %0b frame_last %0b",
                           got.row, got.col, got.value, got.run_last, got.frame_last);
            end else begin
               want = expected_contours.pop_front();
               if (got !== want && log_error()) begin
                  $display("contour mismatch: expected row %0d col %0d value %0d run_last %0b frame_last %0b",
                           want.row, want.col, want.value, want.run_last, want.frame_last);
                  $display("                  actual   row %0d col %0d value %0d run_last %0b frame_last %0b",
                           got.row, got.col, got.value, got.run_last, got.frame_last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin
      int unsigned w, h, count, split;
      logic [CSR_DATA_BITS-1:0] w_reg, h_reg;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_FRAME_WIDTH;
      csr_wdata     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The first row of the full-size reset frame gives no results.
      push_pixels(4);
      set_frame(2, 2);
      pending_pixels = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
      // A zero width acts as one column; an oversized height acts as the maximum.
      set_frame(0, 2047);
      pending_pixels = '{16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE};
      set_frame(1, 0);
      pending_pixels = '{16'h1234, 16'hFFFF, 16'h0000};
      set_frame(3, 3);
      pending_pixels = '{16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF, 16'h8000,
                         16'h7FFF, 16'h0001, 16'hFFFE, 16'h1234};
      // An oversized width acts as the maximum; part of one bottom row.
      set_frame(2047, 1);
      push_pixels(32);

      for (int phase = 0; phase < 4; phase++) begin
         settle(SETTLE_CYCLES);
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         count = 0;
         if (phase == 0) begin
            // The receiver stops while pixels keep coming, so the block fills.
            set_frame(8, 8);
            hold_request++;
            push_pixels(64);
            count = 64;
         end
         while (count < PHASE_PIXELS) begin
            w = ($urandom_range(7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            h = (w > 12) ? $urandom_range(1, 2) : $urandom_range(1, 6);
            w_reg = (w == 1 && $urandom_range(1)) ? '0 : CSR_DATA_BITS'(w);
            h_reg = (h == 1 && $urandom_range(1)) ? '0 : CSR_DATA_BITS'(h);
            set_frame(w_reg, h_reg);
            w = w * h * $urandom_range(1, 2);
            if ($urandom_range(4) == 0) w = $urandom_range(1, w);
            if ($urandom_range(3) == 0) begin
               // The sender pauses partway through until all results are in.
               split = $urandom_range(w);
               push_pixels(split);
               settle(0);
               push_pixels(w - split);
            end else begin
               push_pixels(w);
            end
            count += w;
         end
      end

      settle(SETTLE_CYCLES);
      if (error_count == 0 && expected_contours.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
